// ===== hdl/u8u16_pkg.sv =====
// Shared types, constants and lead-byte decode for the UTF-8 to UTF-16 decoder.
// No dependencies; every module of the block imports this package.
package u8u16_pkg;

   localparam int RUN_MAX     = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] REPLACEMENT_CHAR = 16'hFFFD;
   localparam logic [15:0] SURR_HIGH_BASE   = 16'hD800;
   localparam logic [15:0] SURR_LOW_BASE    = 16'hDC00;
   localparam logic [20:0] SUPP_BASE        = 21'h10000;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        replaced;
      logic        last_unit;
   } rsp_type;

   // A run of bytes to decode as one complete stream; byte 0 is the oldest.
   typedef struct packed {
      logic [RUN_MAX-1:0][7:0] run_bytes;
      logic [2:0]              run_count;
   } job_type;

   // Sequence length that a lead byte announces, 0 when not a lead.
   function automatic logic [2:0] lead_len(input logic [7:0] c);
      logic [2:0] len;
      len = 3'd0;
      if ((c & 8'hE0) == 8'hC0) begin
         len = 3'd2;
      end else if ((c & 8'hF0) == 8'hE0) begin
         len = 3'd3;
      end else if ((c & 8'hF8) == 8'hF0) begin
         len = 3'd4;
      end
      return len;
   endfunction

endpackage

// ===== hdl/utf8_to_utf16_stream_decoder_unit.sv =====
// Top level of the UTF-8 to UTF-16 stream decoder.
// Depends on u8u16_pkg, u8u16_front, u8u16_job_queue and u8u16_back.
//
//   Channel  Ports                          Word
//   req      req_push, req_full, req_data   one UTF-8 byte, end-of-string flag
//   rsp      rsp_pop, rsp_empty, rsp_data   one UTF-16 code unit with flags
//
// One byte is taken per cycle while req_full is low. The back end gives one
// code unit per cycle while rsp is empty or popped; a byte giving several units
// holds that stage until all are out (two for a surrogate pair, up to three
// when a string ends inside a sequence). Bytes pass the run queue, then the
// work and rsp registers. Reset is synchronous and clears held sequence state,
// the queue and rsp. req_full rises while the two-entry run queue is full.
module utf8_to_utf16_stream_decoder_unit
   import u8u16_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic    accept;
   logic    job_valid;
   job_type job;
   logic    q_valid;
   job_type q_job;
   logic    q_pop;

   assign accept = req_push && !req_full;

   u8u16_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job       (job)
   );

   u8u16_job_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_valid),
      .push_job   (job),
      .full       (req_full),
      .head_valid (q_valid),
      .head_job   (q_job),
      .pop        (q_pop)
   );

   u8u16_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_job     (q_job),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/u8u16_front.sv =====
// Front end: takes input words, holds open sequences and hands byte runs on.
// Depends on u8u16_pkg.
module u8u16_front
   import u8u16_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req_data,
   output logic    job_valid,
   output job_type job
);

   logic [2:0][7:0] held_ff, held_in;
   logic [1:0]      held_count_ff, held_count_in;
   logic [2:0]      seq_len_ff, seq_len_in;

   logic [7:0]              b;
   logic [2:0]              len;
   logic [2:0]              n;
   logic [RUN_MAX-1:0][7:0] run;

   always_comb begin
      b   = req_data.data_byte;
      len = lead_len(b);
      n   = {1'b0, held_count_ff} + 3'd1;
      run = {8'h00, held_ff};
      run[held_count_ff] = b;

      held_in       = held_ff;
      held_count_in = held_count_ff;
      seq_len_in    = seq_len_ff;
      job_valid     = 1'b0;
      job.run_bytes = {24'h000000, b};
      job.run_count = 3'd1;

      if (accept) begin
         if (seq_len_ff == 3'd0) begin
            if ((len != 3'd0) && !req_data.end_of_string) begin
               // open a sequence and wait for its continuations
               held_in[0]    = b;
               held_count_in = 2'd1;
               seq_len_in    = len;
            end else begin
               job_valid = 1'b1;
            end
         end else if ((n >= seq_len_ff) || req_data.end_of_string) begin
            job_valid     = 1'b1;
            job.run_bytes = run;
            job.run_count = n;
            held_count_in = 2'd0;
            seq_len_in    = 3'd0;
         end else begin
            held_in[held_count_ff] = b;
            held_count_in          = n[1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (reset) begin
         held_count_ff <= 2'd0;
         seq_len_ff    <= 3'd0;
      end else begin
         held_count_ff <= held_count_in;
         seq_len_ff    <= seq_len_in;
      end
   end

endmodule

// ===== hdl/u8u16_job_queue.sv =====
// Short queue of byte runs between the front end and the decode back end.
// Depends on u8u16_pkg.
module u8u16_job_queue
   import u8u16_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   output logic    head_valid,
   output job_type head_job,
   input  logic    pop
);

   job_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      r = p + QPTR_W'(1);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end
      return r;
   endfunction

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/u8u16_back.sv =====
// Back end: walks one byte run at a time and gives one code unit per cycle
// into the result register when free or popped. Depends on u8u16_pkg.
module u8u16_back
   import u8u16_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  job_type q_job,
   output logic    q_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic                    work_valid_ff, work_valid_in;
   logic [RUN_MAX-1:0][7:0] work_bytes_ff, work_bytes_in;
   logic [2:0]              work_left_ff, work_left_in;
   logic                    pend_ff, pend_in;
   logic [9:0]              low_ff, low_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [7:0]              c;
   logic [2:0]              len;
   logic [10:0]             cp2;
   logic [15:0]             cp3;
   logic [20:0]             cp4;
   logic [20:0]             v;
   logic                    out_ready, emit, last, finish, go_pend, rep;
   logic [15:0]             unit;
   logic [2:0]              step, left_next;
   logic [RUN_MAX-1:0][7:0] shifted;

   always_comb begin
      c   = work_bytes_ff[0];
      len = lead_len(c);
      cp2 = {c[4:0], work_bytes_ff[1][5:0]};
      cp3 = {c[3:0], work_bytes_ff[1][5:0], work_bytes_ff[2][5:0]};
      cp4 = {c[2:0], work_bytes_ff[1][5:0], work_bytes_ff[2][5:0], work_bytes_ff[3][5:0]};
      v   = cp4 - SUPP_BASE;

      unit    = {8'h00, c};
      rep     = 1'b0;
      step    = 3'd1;
      go_pend = 1'b0;
      if (pend_ff) begin
         unit = SURR_LOW_BASE + {6'b0, low_ff};
         step = 3'd0;
      end else if (c < 8'h80) begin
         unit = {8'h00, c};
      end else if ((len == 3'd0) || (len > work_left_ff)) begin
         unit = REPLACEMENT_CHAR;
         rep  = 1'b1;
      end else begin
         step = len;
         case (len)
            3'd2: unit = {5'b0, cp2};
            3'd3: unit = cp3;
            default: begin
               if (cp4[20:16] != 5'd0) begin
                  unit    = SURR_HIGH_BASE + {5'b0, v[20:10]};
                  go_pend = 1'b1;
               end else begin
                  unit = cp4[15:0];
               end
            end
         endcase
      end

      left_next = work_left_ff - step;
      last      = (left_next == 3'd0) && !go_pend;

      case (step)
         3'd0:    shifted = work_bytes_ff;
         3'd1:    shifted = {8'h00, work_bytes_ff[3:1]};
         3'd2:    shifted = {16'h0000, work_bytes_ff[3:2]};
         3'd3:    shifted = {24'h000000, work_bytes_ff[3]};
         default: shifted = '0;
      endcase

      out_ready = !rsp_valid_ff || rsp_pop;
      emit      = work_valid_ff && out_ready;
      finish    = emit && last;
      q_pop     = q_valid && (!work_valid_ff || finish);

      work_valid_in = work_valid_ff;
      work_bytes_in = work_bytes_ff;
      work_left_in  = work_left_ff;
      pend_in       = pend_ff;
      low_in        = low_ff;
      if (emit) begin
         // advance past the bytes just used
         work_valid_in = !last;
         work_bytes_in = shifted;
         work_left_in  = left_next;
         pend_in       = go_pend;
         if (go_pend) begin
            low_in = v[9:0];
         end
      end
      if (q_pop) begin
         work_valid_in = 1'b1;
         work_bytes_in = q_job.run_bytes;
         work_left_in  = q_job.run_count;
         pend_in       = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.code_unit   = unit;
         rsp_in.replaced    = rep;
         rsp_in.last_unit   = last;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      work_bytes_ff <= work_bytes_in;
      work_left_ff  <= work_left_in;
      low_ff        <= low_in;
      rsp_ff        <= rsp_in;
      if (reset) begin
         work_valid_ff <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule
